@@ rtl/core/color_key_sprite_blitter_top_assert.svh @@
// Assertion macros used by the sprite blitter controller.
`ifndef COLOR_KEY_SPRITE_BLITTER_TOP_ASSERT_SVH
`define COLOR_KEY_SPRITE_BLITTER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every edge outside reset.
`define CKB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CKB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/ckb_pkg.sv @@
// Types and constants for the color key sprite blitter.
package ckb_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_X        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_Y        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ERASE_COLOR   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BLIT_MODE     = 3'd7;

  typedef struct packed {
    logic        first_pixel;
    logic [31:0] pixel_color;
  } in_t;

  typedef struct packed {
    logic        write_valid;
    logic        target_buffer;
    logic [23:0] byte_offset;
    logic [31:0] write_data;
  } out_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;  // take the input transfer, step counters
    logic mul;   // row times screen width
    logic fin;   // finish offset, load output register
  } cmd_t;

endpackage

@@ rtl/core/color_key_sprite_blitter_top.sv @@
// Top level of the color key sprite blitter.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_ready   in_data   (in_t)
//   out       output     out_valid / out_ready out_data  (out_t)
//   cfg       input      cfg_we                cfg_index, cfg_data
//
// Each pixel goes through accept, row times screen width multiply, and offset finish, in that order.
// The output register frees the input side; a new pixel is taken while a result waits.
// When the output register is still full at finish, the pixel holds until out_ready.
// Synchronous reset rst restores the register defaults and clears both counters.
module color_key_sprite_blitter_top
  import ckb_pkg::*;
#(
  parameter int MAX_WIDTH   = 2048,
  parameter int MAX_HEIGHT  = 2048,
  parameter int PIXEL_BYTES = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data
);

  cmd_t cmd;

  ckb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ckb_dp #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .PIXEL_BYTES (PIXEL_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule

@@ rtl/core/ckb_ctrl.sv @@
// Sequencing controller for the sprite blitter.
`include "color_key_sprite_blitter_top_assert.svh"

module ckb_ctrl
  import ckb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        // wait here while the previous result is still unclaimed
        if (out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `CKB_ASSERT_NEXT(a_load_to_mul, in_valid && in_ready, state == S_MUL, "accept did not start multiply")
  `CKB_ASSERT_NEXT(a_mul_to_fin, state == S_MUL, state == S_FIN, "multiply step not followed by finish")
  `CKB_ASSERT_NOW(a_fin_slot_free, cmd.fin, !out_valid || out_ready, "result overwrote pending output")
  `CKB_ASSERT_NOW(a_valid_from_fin, $rose(out_valid), $past(cmd.fin), "output valid without finish step")

endmodule

@@ rtl/core/ckb_dp.sv @@
// Datapath: config registers, sprite counters, clipping and offset math.
module ckb_dp
  import ckb_pkg::*;
#(
  parameter int MAX_WIDTH   = 2048,
  parameter int MAX_HEIGHT  = 2048,
  parameter int PIXEL_BYTES = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_t                   in_data,
  input  cmd_t                  cmd,
  output out_t                  out_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int XW   = ((CW > 11) ? CW : 11) + 1;
  localparam int YW   = ((RW > 11) ? RW : 11) + 1;
  localparam int CMPW = ((CW + 1) > 12) ? (CW + 1) : 12;
  localparam logic [31:0] PIX_MASK = 32'((64'd1 << (8 * PIXEL_BYTES)) - 64'd1);

  logic [11:0] screen_width;
  logic [11:0] screen_height;
  logic [10:0] dest_x;
  logic [10:0] dest_y;
  logic [11:0] image_width;
  logic [31:0] key_color;
  logic [31:0] erase_color;
  logic [1:0]  blit_mode;

  logic [CW-1:0] col;
  logic [RW-1:0] row;

  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  logic [CW:0]   col_inc;
  logic          col_wrap;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic [XW-1:0] x_sum;
  logic [YW-1:0] y_sum;
  logic [31:0]   color_m;
  logic          hit;

  // stage registers
  logic [XW-1:0] s_x;
  logic [YW-1:0] s_y;
  logic [31:0]   s_color;
  logic          s_hit;
  logic [23:0]   prod;
  logic [23:0]   pix_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 12'd1024;
      screen_height <= 12'd768;
      dest_x        <= '0;
      dest_y        <= '0;
      image_width   <= 12'd1;
      key_color     <= '0;
      erase_color   <= '0;
      blit_mode     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data[11:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[11:0];
        REG_DEST_X:        dest_x        <= cfg_data[10:0];
        REG_DEST_Y:        dest_y        <= cfg_data[10:0];
        REG_IMAGE_WIDTH:   image_width   <= cfg_data[11:0];
        REG_KEY_COLOR:     key_color     <= cfg_data;
        REG_ERASE_COLOR:   erase_color   <= cfg_data;
        REG_BLIT_MODE:     blit_mode     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cur_col  = in_data.first_pixel ? '0 : col;
    cur_row  = in_data.first_pixel ? '0 : row;
    col_inc  = (CW + 1)'(cur_col) + (CW + 1)'(1);
    col_wrap = (CMPW'(col_inc) >= CMPW'(image_width)) ||
               (col_inc >= (CW + 1)'(MAX_WIDTH));
    col_next = col_wrap ? '0 : col_inc[CW-1:0];
    if (!col_wrap) begin
      row_next = cur_row;
    end else if (cur_row == RW'(MAX_HEIGHT - 1)) begin
      row_next = '0;
    end else begin
      row_next = cur_row + RW'(1);
    end
    x_sum   = XW'(cur_col) + XW'(dest_x);
    y_sum   = YW'(cur_row) + YW'(dest_y);
    color_m = in_data.pixel_color & PIX_MASK;
    hit     = (color_m != key_color) &&
              (x_sum < XW'(screen_width)) &&
              (y_sum < YW'(screen_height));
  end

  assign pix_index = prod + 24'(s_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cmd.load) begin
      col <= col_next;
      row <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_x     <= x_sum;
      s_y     <= y_sum;
      s_color <= color_m;
      s_hit   <= hit;
    end
    if (cmd.mul) begin
      prod <= 24'(s_y * YW'(screen_width));
    end
    if (cmd.fin) begin
      if (s_hit) begin
        out_data.write_valid   <= 1'b1;
        out_data.target_buffer <= blit_mode[0];
        out_data.byte_offset   <= 24'(pix_index * 24'(PIXEL_BYTES));
        out_data.write_data    <= blit_mode[1] ? (erase_color & PIX_MASK) : s_color;
      end else begin
        out_data <= '0;
      end
    end
  end

endmodule
